[rtl/gds_pkg.sv]
// shared types, constants and helpers of the greedy diagonal sweep block
package gds_pkg;

   localparam int MAX_ROWS   = 16;
   localparam int MAX_COLS   = 16;
   localparam int MAX_PIVOTS = 16;
   localparam int DIV_STEPS  = 64;

   // request modes
   localparam logic [1:0] MODE_WRITE_EL   = 2'd0;
   localparam logic [1:0] MODE_WRITE_CAND = 2'd1;
   localparam logic [1:0] MODE_RUN        = 2'd2;
   localparam logic [1:0] MODE_READ_EL    = 2'd3;

   // register indexes
   localparam logic [2:0] REG_NUM_ROWS   = 3'd0;
   localparam logic [2:0] REG_NUM_COLS   = 3'd1;
   localparam logic [2:0] REG_NUM_PIVOTS = 3'd2;
   localparam logic [2:0] REG_SIGN_TYPE  = 3'd3;
   localparam logic [2:0] REG_EPSILON    = 3'd4;

   // result kinds
   localparam logic KIND_READ   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef struct packed {
      logic [4:0]  num_rows;
      logic [4:0]  num_cols;
      logic [4:0]  num_pivots;
      logic [1:0]  sign_type;
      logic [15:0] epsilon;
   } cfg_type;

   typedef enum logic [1:0] {
      PH_UPD = 2'd0,
      PH_COL = 2'd1,
      PH_ROW = 2'd2,
      PH_PIV = 2'd3
   } phase_type;

   // negative-sign flags {pivot, row, column} per sign type
   function automatic logic [2:0] sign_neg(input logic [1:0] st);
      logic [2:0] r;
      case (st)
         2'd0:    r = 3'b100;
         2'd1:    r = 3'b111;
         2'd2:    r = 3'b010;
         default: r = 3'b001;
      endcase
      return r;
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > $signed({34'h0, 32'h7FFF_FFFF}))
         r = 32'sh7FFF_FFFF;
      else if (v < $signed({34'h3_FFFF_FFFF, 32'h8000_0000}))
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

   // magnitude of a signed 32-bit value
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   // clamp a 5-bit count to a maximum
   function automatic logic [4:0] clamp5(input logic [4:0] v, input logic [4:0] mx);
      logic [4:0] r;
      r = (v > mx) ? mx : v;
      return r;
   endfunction

endpackage

[rtl/gds_div.sv]
// iterative unsigned 64 by 32 restoring divider, one quotient bit per cycle
module gds_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import gds_pkg::*;

   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic        done_ff, done_in;
   logic [32:0] rem_sh;

   // one shift-subtract step
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[31:0], quo_ff[63]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in    = rem_sh - {1'b0, divisor};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = rem_sh;
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // done follows the last step of a busy division
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   // no restart during a division
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   // remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff != 7'd0) |-> (rem_ff < {1'b0, divisor}))
      else $error("divider remainder out of range");

endmodule

[rtl/gds_core.sv]
// sequencer, matrix memory, candidate list, multiplier and divider of the sweep block
module gds_core (
   input  logic                    clock,
   input  logic                    reset,
   input  gds_pkg::cfg_type        cfg,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_mode,
   input  logic [3:0]              req_row,
   input  logic [3:0]              req_col,
   input  logic signed [31:0]      req_value,
   input  logic [3:0]              req_slot,
   input  logic [3:0]              req_candidate,
   output logic                    rsp_valid,
   output logic                    rsp_kind,
   output logic signed [31:0]      rsp_read_value,
   output logic [3:0]              rsp_pivot_index,
   output logic                    rsp_pivot_refused,
   output logic                    rsp_last
);
   import gds_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE       = 16'h0001,
      S_RD_OUT     = 16'h0002,
      S_RUN_INIT   = 16'h0004,
      S_SCAN_START = 16'h0008,
      S_SCAN_ADDR  = 16'h0010,
      S_SCAN_CMP   = 16'h0020,
      S_SCAN_DONE  = 16'h0040,
      S_PIV_GET    = 16'h0080,
      S_ELEM       = 16'h0100,
      S_RD_X       = 16'h0200,
      S_RD_Y       = 16'h0400,
      S_RD_A       = 16'h0800,
      S_MUL        = 16'h1000,
      S_DIV_GO     = 16'h2000,
      S_DIV_WAIT   = 16'h4000,
      S_REPORT     = 16'h8000
   } state_type;

   // matrix memory and candidate list
   logic signed [31:0] mem [MAX_ROWS * MAX_COLS];
   logic [3:0]         cand_ff [MAX_PIVOTS];
   logic signed [31:0] mem_rdata_ff;
   logic               mem_we;
   logic [7:0]         mem_waddr, mem_raddr;
   logic signed [31:0] mem_wdata;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [4:0]         i_ff, i_in, j_ff, j_in, s_ff, s_in, l_ff, l_in;
   logic [3:0]         k_ff, k_in, best_ff, best_in;
   logic [31:0]        best_mag_ff, best_mag_in;
   logic               found_ff, found_in;
   logic [15:0]        used_ff, used_in;
   logic signed [31:0] piv_ff, piv_in, x_ff, x_in, y_ff, y_in, a_ff, a_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               refused_ff, refused_in;
   logic               rv_ff, rv_in, rk_ff, rk_in, rr_ff, rr_in, rl_ff, rl_in;
   logic signed [31:0] rval_ff, rval_in;
   logic [3:0]         ridx_ff, ridx_in;

   logic [4:0]         n_use, m_use, p_use;
   logic [2:0]         sneg;
   logic               div_start, div_done;
   logic [63:0]        div_q, prod_mag;
   logic [31:0]        piv_mag, scan_mag;
   logic [3:0]         cand_s;
   logic               neg_q;
   logic signed [65:0] qs, res66;
   logic               is_last;

   assign n_use    = clamp5(cfg.num_rows, 5'(MAX_ROWS));
   assign m_use    = clamp5(cfg.num_cols, 5'(MAX_COLS));
   assign p_use    = clamp5(cfg.num_pivots, 5'(MAX_PIVOTS));
   assign sneg     = sign_neg(cfg.sign_type);
   assign prod_mag = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
   assign piv_mag  = mag32(piv_ff);
   assign scan_mag = mag32(mem_rdata_ff);
   assign cand_s   = cand_ff[s_ff[3:0]];
   assign div_start = (state_ff == S_DIV_GO);
   assign is_last  = ((l_ff + 5'd1) == p_use);

   gds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_mag),
      .divisor  (piv_mag),
      .done     (div_done),
      .quotient (div_q)
   );

   // signed quotient and the value to write back
   always_comb begin
      neg_q = prod_ff[63] ^ piv_ff[31];
      case (phase_ff)
         PH_COL:  neg_q = neg_q ^ sneg[0];
         PH_ROW:  neg_q = neg_q ^ sneg[1];
         PH_PIV:  neg_q = neg_q ^ sneg[2];
         default: neg_q = neg_q;
      endcase
      qs = neg_q ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
      if (phase_ff == PH_UPD)
         res66 = $signed({{34{a_ff[31]}}, a_ff}) - qs;
      else
         res66 = qs;
   end

   // memory read address
   always_comb begin
      mem_raddr = {req_row, req_col};
      unique case (state_ff)
         S_SCAN_ADDR: mem_raddr = {cand_s, cand_s};
         S_SCAN_DONE: mem_raddr = {cand_ff[best_ff], cand_ff[best_ff]};
         S_ELEM: begin
            if (phase_ff == PH_ROW) mem_raddr = {k_ff, j_ff[3:0]};
            else                    mem_raddr = {i_ff[3:0], k_ff};
         end
         S_RD_X:  mem_raddr = {k_ff, j_ff[3:0]};
         S_RD_Y:  mem_raddr = {i_ff[3:0], j_ff[3:0]};
         default: mem_raddr = {req_row, req_col};
      endcase
   end

   // memory write port: element writes when idle, sweep results otherwise
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {req_row, req_col};
      mem_wdata = req_value;
      if (state_ff == S_IDLE) begin
         mem_we = start && (req_mode == MODE_WRITE_EL);
      end else if (state_ff == S_DIV_WAIT && div_done) begin
         mem_we    = 1'b1;
         mem_wdata = sat66(res66);
         case (phase_ff)
            PH_UPD:  mem_waddr = {i_ff[3:0], j_ff[3:0]};
            PH_COL:  mem_waddr = {i_ff[3:0], k_ff};
            PH_ROW:  mem_waddr = {k_ff, j_ff[3:0]};
            default: mem_waddr = {k_ff, k_ff};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   // candidate writes
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start && req_mode == MODE_WRITE_CAND)
         cand_ff[req_slot] <= req_candidate;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      s_in        = s_ff;
      l_in        = l_ff;
      k_in        = k_ff;
      best_in     = best_ff;
      best_mag_in = best_mag_ff;
      found_in    = found_ff;
      used_in     = used_ff;
      piv_in      = piv_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      a_in        = a_ff;
      prod_in     = prod_ff;
      refused_in  = refused_ff;
      rv_in       = 1'b0;
      rk_in       = rk_ff;
      rval_in     = rval_ff;
      ridx_in     = ridx_ff;
      rr_in       = rr_ff;
      rl_in       = rl_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_READ_EL: state_in = S_RD_OUT;
                  MODE_RUN:     state_in = S_RUN_INIT;
                  default:      state_in = S_IDLE;
               endcase
            end
         end
         S_RD_OUT: begin
            rv_in    = 1'b1;
            rk_in    = KIND_READ;
            rval_in  = mem_rdata_ff;
            ridx_in  = '0;
            rr_in    = 1'b0;
            rl_in    = 1'b1;
            state_in = S_IDLE;
         end
         S_RUN_INIT: begin
            used_in  = '0;
            l_in     = '0;
            state_in = (p_use == 5'd0) ? S_IDLE : S_SCAN_START;
         end
         S_SCAN_START: begin
            s_in     = '0;
            found_in = 1'b0;
            state_in = S_SCAN_ADDR;
         end
         S_SCAN_ADDR: begin
            if (s_ff == p_use)            state_in = S_SCAN_DONE;
            else if (used_ff[s_ff[3:0]])  s_in = s_ff + 5'd1;
            else                          state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (!found_ff || scan_mag > best_mag_ff) begin
               found_in    = 1'b1;
               best_in     = s_ff[3:0];
               best_mag_in = scan_mag;
            end
            s_in     = s_ff + 5'd1;
            state_in = S_SCAN_ADDR;
         end
         S_SCAN_DONE: begin
            used_in[best_ff] = 1'b1;
            k_in     = cand_ff[best_ff];
            state_in = S_PIV_GET;
         end
         S_PIV_GET: begin
            piv_in = mem_rdata_ff;
            if (mem_rdata_ff == 32'sd0 || scan_mag < {16'h0, cfg.epsilon}) begin
               refused_in = 1'b1;
               state_in   = S_REPORT;
            end else begin
               refused_in = 1'b0;
               phase_in   = PH_UPD;
               i_in       = '0;
               j_in       = '0;
               state_in   = S_ELEM;
            end
         end
         S_ELEM: begin
            case (phase_ff)
               PH_UPD: begin
                  if (i_ff == n_use) begin
                     phase_in = PH_COL;
                     i_in     = '0;
                  end else if (j_ff == m_use) begin
                     i_in = i_ff + 5'd1;
                     j_in = '0;
                  end else if (i_ff == {1'b0, k_ff} || j_ff == {1'b0, k_ff}) begin
                     j_in = j_ff + 5'd1;
                  end else begin
                     state_in = S_RD_X;
                  end
               end
               PH_COL: begin
                  if (i_ff == n_use) begin
                     phase_in = PH_ROW;
                     j_in     = '0;
                  end else if (i_ff == {1'b0, k_ff}) begin
                     i_in = i_ff + 5'd1;
                  end else begin
                     state_in = S_RD_X;
                  end
               end
               PH_ROW: begin
                  if (j_ff == m_use) begin
                     phase_in = PH_PIV;
                  end else if (j_ff == {1'b0, k_ff}) begin
                     j_in = j_ff + 5'd1;
                  end else begin
                     state_in = S_RD_X;
                  end
               end
               default: begin
                  // reciprocal of the pivot: 2^32 as 2^16 times 2^16
                  x_in     = 32'sd65536;
                  y_in     = 32'sd65536;
                  state_in = S_MUL;
               end
            endcase
         end
         S_RD_X: begin
            x_in = mem_rdata_ff;
            if (phase_ff == PH_UPD) begin
               state_in = S_RD_Y;
            end else begin
               y_in     = 32'sd65536;
               state_in = S_MUL;
            end
         end
         S_RD_Y: begin
            y_in     = mem_rdata_ff;
            state_in = S_RD_A;
         end
         S_RD_A: begin
            a_in     = mem_rdata_ff;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = x_ff * y_ff;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               case (phase_ff)
                  PH_UPD:  begin j_in = j_ff + 5'd1; state_in = S_ELEM;   end
                  PH_COL:  begin i_in = i_ff + 5'd1; state_in = S_ELEM;   end
                  PH_ROW:  begin j_in = j_ff + 5'd1; state_in = S_ELEM;   end
                  default: state_in = S_REPORT;
               endcase
            end
         end
         S_REPORT: begin
            rv_in    = 1'b1;
            rk_in    = KIND_REPORT;
            rval_in  = '0;
            ridx_in  = k_ff;
            rr_in    = refused_ff;
            rl_in    = is_last;
            l_in     = l_ff + 5'd1;
            state_in = is_last ? S_IDLE : S_SCAN_START;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         rv_ff    <= rv_in;
      end
      phase_ff    <= phase_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      s_ff        <= s_in;
      l_ff        <= l_in;
      k_ff        <= k_in;
      best_ff     <= best_in;
      best_mag_ff <= best_mag_in;
      found_ff    <= found_in;
      piv_ff      <= piv_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      a_ff        <= a_in;
      prod_ff     <= prod_in;
      refused_ff  <= refused_in;
      rk_ff       <= rk_in;
      rval_ff     <= rval_in;
      ridx_ff     <= ridx_in;
      rr_ff       <= rr_in;
      rl_ff       <= rl_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rv_ff;
   assign rsp_kind          = rk_ff;
   assign rsp_read_value    = rval_ff;
   assign rsp_pivot_index   = ridx_ff;
   assign rsp_pivot_refused = rr_ff;
   assign rsp_last          = rl_ff;

   // a result strobe comes only from a read or a round report
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> $past(state_ff == S_RD_OUT || state_ff == S_REPORT))
      else $error("result strobe without source");
   // every reported round has marked exactly one more candidate used
   a_used_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPORT) |-> ($countones(used_ff) == 32'(l_ff) + 32'd1))
      else $error("candidate used count mismatch");
   // divider results arrive only while waiting for them
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider result while not waiting");

endmodule

[rtl/greedy_diagonal_sweep.sv]
// top level of the greedy diagonal sweep block: register file and core
//
// Usage:
//   Items enter on the req_ ports and are transferred at a clock edge with
//   start high and busy low. Mode 0 writes a matrix element and mode 1 a
//   candidate slot; neither gives a result. Mode 3 reads an element: busy
//   for one cycle, the read data strobes on rsp_valid from the result
//   register that S_RD_OUT loads. Mode 2 runs num_pivots rounds and gives
//   one pivot report per round, rsp_last on the final one.
//   Each round scans the candidate list; a swept pivot then does a multiply
//   and a divide for each touched element (up to (rows-1)*(cols-1) +
//   rows + cols - 1 of them) on the shared 64-step restoring divider.
//   Registers are written through csr_ (valid/ready, index, data) while the
//   block is idle, a rule for the user that the block does not enforce;
//   csr_ready is always high. Results hold for one cycle only; the
//   receiver cannot stall them. Synchronous reset returns the registers
//   to 16, 16, 1, 0, 7 and the sequencer to idle; matrix and candidate
//   contents are undefined until written.
module greedy_diagonal_sweep (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [3:0]         req_row,
   input  logic [3:0]         req_col,
   input  logic signed [31:0] req_value,
   input  logic [3:0]         req_slot,
   input  logic [3:0]         req_candidate,
   output logic               rsp_valid,
   output logic               rsp_kind,
   output logic signed [31:0] rsp_read_value,
   output logic [3:0]         rsp_pivot_index,
   output logic               rsp_pivot_refused,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import gds_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_NUM_ROWS:   cfg_in.num_rows   = csr_data[4:0];
            REG_NUM_COLS:   cfg_in.num_cols   = csr_data[4:0];
            REG_NUM_PIVOTS: cfg_in.num_pivots = csr_data[4:0];
            REG_SIGN_TYPE:  cfg_in.sign_type  = csr_data[1:0];
            REG_EPSILON:    cfg_in.epsilon    = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_rows   <= 5'd16;
         cfg_ff.num_cols   <= 5'd16;
         cfg_ff.num_pivots <= 5'd1;
         cfg_ff.sign_type  <= 2'd0;
         cfg_ff.epsilon    <= 16'd7;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   gds_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_value         (req_value),
      .req_slot          (req_slot),
      .req_candidate     (req_candidate),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_read_value    (rsp_read_value),
      .rsp_pivot_index   (rsp_pivot_index),
      .rsp_pivot_refused (rsp_pivot_refused),
      .rsp_last          (rsp_last)
   );

endmodule
